@@ hw/rtl/h4d_pkg.sv @@
// ----------------------------------------------------------------------------
// H4 deframer package
// Item types, packet kind and byte role codes shared by the deframer files.
// ----------------------------------------------------------------------------
package h4d_pkg;

    localparam logic [15:0] ACL_LIMIT_RESET = 16'd1020;

    localparam logic [7:0] IND_ACL   = 8'd2;
    localparam logic [7:0] IND_SYNC  = 8'd3;
    localparam logic [7:0] IND_EVENT = 8'd4;

    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_ACL   = 2'd1;
    localparam logic [1:0] KIND_SYNC  = 2'd2;
    localparam logic [1:0] KIND_EVENT = 2'd3;

    localparam logic [1:0] ROLE_IND     = 2'd0;
    localparam logic [1:0] ROLE_HDR     = 2'd1;
    localparam logic [1:0] ROLE_PAY     = 2'd2;
    localparam logic [1:0] ROLE_IGNORED = 2'd3;

    localparam logic [2:0] HDR_LEN_ACL   = 3'd4;
    localparam logic [2:0] HDR_LEN_SYNC  = 3'd3;
    localparam logic [2:0] HDR_LEN_EVENT = 3'd2;

    // ACL header offset of the low length byte
    localparam logic [2:0] ACL_LEN_LOW_OFS = 3'd2;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       read_error;
    } rx_item_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic [1:0] packet_kind;
        logic [1:0] byte_role;
        logic       first_of_packet;
        logic       last_of_packet;
        logic       hard_reset_request;
        logic       halted;
    } pkt_item_t;

endpackage

@@ hw/rtl/h4d_parser.sv @@
// ----------------------------------------------------------------------------
// H4 deframer parser
// Holds framing state and tags one byte per step with kind, role and flags.
// ----------------------------------------------------------------------------
module h4d_parser
    import h4d_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  rx_item_t    item,
    input  logic [15:0] acl_limit,
    output pkt_item_t   result
);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_HEADER,
        PH_PAYLOAD,
        PH_HALTED
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [1:0]  kind_reg, kind_next;
    logic [2:0]  hdr_cnt_reg, hdr_cnt_next;
    logic [7:0]  len_low_reg, len_low_next;
    logic [15:0] remaining_reg, remaining_next;

    logic [7:0]  b;
    logic [2:0]  hdr_len;
    logic        hdr_done;
    logic        first;
    logic [15:0] len;

    assign b     = item.rx_byte;
    assign first = (hdr_cnt_reg == 3'd0);

    always_comb
    begin
        hdr_len = 3'd0;
        if (kind_reg == KIND_ACL)
        begin
            hdr_len = HDR_LEN_ACL;
        end
        else if (kind_reg == KIND_SYNC)
        begin
            hdr_len = HDR_LEN_SYNC;
        end
        else if (kind_reg == KIND_EVENT)
        begin
            hdr_len = HDR_LEN_EVENT;
        end
        hdr_done = (({1'b0, hdr_cnt_reg} + 4'd1) >= {1'b0, hdr_len});
        len      = (kind_reg == KIND_ACL) ? {b, len_low_reg} : {8'd0, b};
    end

    always_comb
    begin
        phase_next     = phase_reg;
        kind_next      = kind_reg;
        hdr_cnt_next   = hdr_cnt_reg;
        len_low_next   = len_low_reg;
        remaining_next = remaining_reg;

        result                    = '0;
        result.data_byte          = b;
        result.packet_kind        = kind_reg;

        if (phase_reg == PH_HALTED)
        begin
            result.packet_kind = KIND_NONE;
            result.byte_role   = ROLE_IGNORED;
            result.halted      = 1'b1;
        end
        else if (item.read_error)
        begin
            result.byte_role          = ROLE_IGNORED;
            result.hard_reset_request = 1'b1;
            result.halted             = 1'b1;
            phase_next                = PH_HALTED;
        end
        else
        begin
            unique case (phase_reg)
                PH_IDLE:
                begin
                    result.byte_role = ROLE_IND;
                    hdr_cnt_next     = 3'd0;
                    phase_next       = PH_HEADER;
                    if (b == IND_ACL)
                    begin
                        kind_next = KIND_ACL;
                    end
                    else if (b == IND_SYNC)
                    begin
                        kind_next = KIND_SYNC;
                    end
                    else if (b == IND_EVENT)
                    begin
                        kind_next = KIND_EVENT;
                    end
                    else
                    begin
                        kind_next                 = kind_reg;
                        phase_next                = PH_HALTED;
                        result.hard_reset_request = 1'b1;
                        result.halted             = 1'b1;
                    end
                    result.packet_kind = (phase_next == PH_HALTED) ? KIND_NONE : kind_next;
                end
                PH_HEADER:
                begin
                    result.byte_role       = ROLE_HDR;
                    result.first_of_packet = first;
                    if (kind_reg == KIND_NONE)
                    begin
                        result.hard_reset_request = 1'b1;
                        result.halted             = 1'b1;
                        phase_next                = PH_HALTED;
                    end
                    else
                    begin
                        if (kind_reg == KIND_ACL && hdr_cnt_reg == ACL_LEN_LOW_OFS)
                        begin
                            len_low_next = b;
                        end
                        if (!hdr_done)
                        begin
                            hdr_cnt_next = hdr_cnt_reg + 3'd1;
                        end
                        else if (kind_reg == KIND_ACL && len > acl_limit)
                        begin
                            result.hard_reset_request = 1'b1;
                            result.halted             = 1'b1;
                            phase_next                = PH_HALTED;
                        end
                        else if (len == 16'd0)
                        begin
                            result.last_of_packet = 1'b1;
                            phase_next            = PH_IDLE;
                            kind_next             = KIND_NONE;
                            hdr_cnt_next          = 3'd0;
                            len_low_next          = 8'd0;
                            remaining_next        = 16'd0;
                        end
                        else
                        begin
                            remaining_next = len;
                            hdr_cnt_next   = 3'd0;
                            phase_next     = PH_PAYLOAD;
                        end
                    end
                end
                PH_PAYLOAD:
                begin
                    result.byte_role = ROLE_PAY;
                    if (remaining_reg <= 16'd1)
                    begin
                        result.last_of_packet = 1'b1;
                        phase_next            = PH_IDLE;
                        kind_next             = KIND_NONE;
                        hdr_cnt_next          = 3'd0;
                        len_low_next          = 8'd0;
                        remaining_next        = 16'd0;
                    end
                    else
                    begin
                        remaining_next = remaining_reg - 16'd1;
                    end
                end
                PH_HALTED:
                begin
                    result.byte_role = ROLE_IGNORED;
                    result.halted    = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            kind_reg      <= KIND_NONE;
            hdr_cnt_reg   <= 3'd0;
            len_low_reg   <= 8'd0;
            remaining_reg <= 16'd0;
        end
        else if (step)
        begin
            phase_reg     <= phase_next;
            kind_reg      <= kind_next;
            hdr_cnt_reg   <= hdr_cnt_next;
            len_low_reg   <= len_low_next;
            remaining_reg <= remaining_next;
        end
    end

endmodule

@@ hw/rtl/h4_uart_hci_packet_deframer.sv @@
// An accepted byte goes through the input register, then the result register,
// to the output. Throughput: one byte per cycle while the output side takes
// items; a two-entry result buffer lets the input keep accepting while one
// result waits. Reset clears framing state, empties all stages and sets the
// ACL payload limit to 1020; a halt lasts until reset.
// ----------------------------------------------------------------------------
// H4 UART HCI packet deframer
// Splits received UART bytes into H4 packets and tags each byte.
// ----------------------------------------------------------------------------
module h4_uart_hci_packet_deframer
    import h4d_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        rx_valid,
    output logic        rx_stall,
    input  rx_item_t    rx_item,
    output logic        pkt_valid,
    input  logic        pkt_stall,
    output pkt_item_t   pkt_item,
    input  logic        cfg_write_enable,
    input  logic [15:0] cfg_write_data
);

    logic [15:0] acl_limit_reg;
    logic        in_valid_reg;
    rx_item_t    in_item_reg;
    logic        out_valid_reg;
    pkt_item_t   out_item_reg;
    logic        skid_valid_reg;
    pkt_item_t   skid_item_reg;

    logic        accept;
    logic        advance;
    logic        pop;
    pkt_item_t   result;

    assign rx_stall  = in_valid_reg && out_valid_reg && skid_valid_reg;
    assign accept    = rx_valid && !rx_stall;
    assign advance   = in_valid_reg && !(out_valid_reg && skid_valid_reg);
    assign pop       = out_valid_reg && !pkt_stall;
    assign pkt_valid = out_valid_reg;
    assign pkt_item  = out_item_reg;

    h4d_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .item      (in_item_reg),
        .acl_limit (acl_limit_reg),
        .result    (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acl_limit_reg <= ACL_LIMIT_RESET;
        end
        else if (cfg_write_enable)
        begin
            acl_limit_reg <= cfg_write_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_item_reg <= rx_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= advance;
            end
            else
            begin
                out_valid_reg <= advance;
            end
        end
        else if (advance)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                out_item_reg <= skid_item_reg;
                if (advance)
                begin
                    skid_item_reg <= result;
                end
            end
            else if (advance)
            begin
                out_item_reg <= result;
            end
        end
        else if (advance)
        begin
            skid_item_reg <= result;
        end
    end

endmodule

@@ hw/rtl/h4d_checker.sv @@
// ----------------------------------------------------------------------------
// H4 deframer checker
// Port-level assertions on halt behavior, packet marks and item balance.
// ----------------------------------------------------------------------------
module h4d_checker
    import h4d_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        rx_valid,
    input  logic        rx_stall,
    input  logic        pkt_valid,
    input  logic        pkt_stall,
    input  pkt_item_t   pkt_item
);

    logic       in_acc;
    logic       out_acc;
    logic       seen_halt_reg;
    logic [1:0] prev_role_reg;
    logic [1:0] prev_kind_reg;
    logic [2:0] pending_reg;

    assign in_acc  = rx_valid && !rx_stall;
    assign out_acc = pkt_valid && !pkt_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_halt_reg <= 1'b0;
            prev_role_reg <= ROLE_IGNORED;
            prev_kind_reg <= KIND_NONE;
            pending_reg   <= 3'd0;
        end
        else
        begin
            if (out_acc)
            begin
                seen_halt_reg <= seen_halt_reg || pkt_item.halted;
                prev_role_reg <= pkt_item.byte_role;
                prev_kind_reg <= pkt_item.packet_kind;
            end
            pending_reg <= pending_reg + {2'd0, in_acc} - {2'd0, out_acc};
        end
    end

    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc && seen_halt_reg |-> pkt_item.halted && !pkt_item.hard_reset_request
            && pkt_item.byte_role == ROLE_IGNORED)
        else $error("item after halt not ignored");

    a_request_halts: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc && pkt_item.hard_reset_request |-> pkt_item.halted && !seen_halt_reg)
        else $error("hard reset request without fresh halt");

    a_first_after_ind: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc && pkt_item.first_of_packet |-> prev_role_reg == ROLE_IND
            && prev_kind_reg != KIND_NONE && pkt_item.byte_role == ROLE_HDR)
        else $error("first mark not right after an indicator");

    a_last_in_packet: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc && pkt_item.last_of_packet |-> pkt_item.packet_kind != KIND_NONE
            && (pkt_item.byte_role == ROLE_HDR || pkt_item.byte_role == ROLE_PAY))
        else $error("last mark outside a packet");

    a_item_balance: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= 3'd3)
        else $error("items lost or invented");

endmodule

bind h4_uart_hci_packet_deframer h4d_checker u_h4d_checker (.*);
